@@ rtl/dss_spad_select_and_range_scaler_top_macros.svh @@
// Assertion macros shared by the SPAD select and range scaler RTL.
`ifndef DSS_SPAD_SELECT_AND_RANGE_SCALER_TOP_MACROS_SVH
`define DSS_SPAD_SELECT_AND_RANGE_SCALER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset.
`define DSS_SPAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dss_spad same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DSS_SPAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dss_spad next-cycle check failed");

`else

`define DSS_SPAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSS_SPAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/dss_spad_pkg.sv @@
// Types and constants shared by the SPAD select and range scaler.
`timescale 1ns / 1ps

package dss_spad_pkg;

    // one ranging result, first field in the highest bits
    typedef struct packed {
        logic [15:0] raw_range;
        logic [15:0] ambient_rate;
        logic [15:0] peak_rate;
        logic [15:0] effective_spads;
    } t_item;

    // per-item flags and scaled distance carried alongside the dividers
    typedef struct packed {
        logic        dflt;
        logic        sat;
        logic [15:0] dist_mm;
    } t_side;

    localparam logic [15:0] SPAD_DEFAULT = 16'h8000;
    localparam logic [15:0] SAT16        = 16'hFFFF;
    localparam logic [15:0] TARGET_RESET = 16'd2560;
    localparam logic [26:0] RANGE_MUL    = 27'd2011;
    localparam logic [26:0] RANGE_RND    = 27'h0000400;

    // register index taken from paddr[2]
    localparam logic        REG_TARGET   = 1'b0;

    localparam int unsigned DIV1_STEPS   = 32;
    localparam int unsigned DIV2_STEPS   = 16;

endpackage

@@ rtl/dss_spad_front.sv @@
// Entry stage: saturated rate sum and rounded range scaling.
`timescale 1ns / 1ps

module dss_spad_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  dss_spad_pkg::t_item  i_item,
    output logic                 o_vld,
    output logic [15:0]          o_rate,
    output logic [15:0]          o_spads,
    output dss_spad_pkg::t_side  o_side
);

    logic [16:0]         w_sum;
    logic [26:0]         w_prod;
    logic [26:0]         w_scaled;
    logic                r_vld;
    logic [15:0]         r_rate;
    logic [15:0]         r_spads;
    dss_spad_pkg::t_side r_side;
    logic [15:0]         n_rate;
    dss_spad_pkg::t_side n_side;

    always_comb begin
        w_sum    = {1'b0, i_item.peak_rate} + {1'b0, i_item.ambient_rate};
        n_rate   = w_sum[16] ? dss_spad_pkg::SAT16 : w_sum[15:0];
        w_prod   = 27'(i_item.raw_range) * dss_spad_pkg::RANGE_MUL;
        w_scaled = w_prod + dss_spad_pkg::RANGE_RND;
        // drop the eleven fraction bits
        n_side.dist_mm = w_scaled[26:11];
        n_side.dflt    = (i_item.effective_spads == 16'd0);
        n_side.sat     = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rate  <= n_rate;
            r_spads <= i_item.effective_spads;
            r_side  <= n_side;
        end
    end

    assign o_vld   = r_vld;
    assign o_rate  = r_rate;
    assign o_spads = r_spads;
    assign o_side  = r_side;

endmodule

@@ rtl/dss_spad_div_cell.sv @@
// One restoring-division cell: one quotient bit per cell, handed on each cycle that i_en is high.
`timescale 1ns / 1ps

module dss_spad_div_cell #(
    parameter int unsigned RW = 16,
    parameter int unsigned DW = 32,
    parameter int unsigned SW = 18
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_quo,
    input  logic [RW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [RW-1:0] o_rem,
    output logic [DW-1:0] o_quo,
    output logic [RW-1:0] o_div,
    output logic [SW-1:0] o_side
);

    logic [RW:0]   w_trial;
    logic [RW:0]   w_diff;
    logic          w_ge;
    logic          r_vld;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [RW-1:0] r_div;
    logic [SW-1:0] r_side;
    logic [RW-1:0] n_rem;
    logic [DW-1:0] n_quo;

    always_comb begin
        // bring down the next dividend bit, subtract where it fits
        w_trial = {i_rem, i_quo[DW-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
        n_quo   = {i_quo[DW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

@@ rtl/dss_spad_join.sv @@
// Stage between the dividers: flag checks and set-up of the second division.
`timescale 1ns / 1ps

module dss_spad_join (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [31:0]          i_per_spad,
    input  dss_spad_pkg::t_side  i_side,
    input  logic [15:0]          i_target,
    output logic                 o_vld,
    output logic [31:0]          o_rem,
    output logic [15:0]          o_quo,
    output logic [31:0]          o_div,
    output dss_spad_pkg::t_side  o_side
);

    logic                r_vld;
    logic [15:0]         r_target;
    logic [31:0]         r_div;
    dss_spad_pkg::t_side r_side;
    dss_spad_pkg::t_side n_side;

    always_comb begin
        n_side      = i_side;
        n_side.dflt = i_side.dflt || (i_per_spad == 32'd0);
        // quotient reaches 2^16 exactly when the divisor is not above the target
        n_side.sat  = (i_per_spad <= {16'd0, i_target});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_target <= i_target;
            r_div    <= i_per_spad;
            r_side   <= n_side;
        end
    end

    // the upper sixteen quotient bits are zero, so start with the target as remainder
    assign o_vld  = r_vld;
    assign o_rem  = {16'd0, r_target};
    assign o_quo  = 16'd0;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

@@ rtl/dss_spad_out.sv @@
// Output register: final SPAD select, default flag and distance.
`timescale 1ns / 1ps

module dss_spad_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic [15:0]          i_quo,
    input  dss_spad_pkg::t_side  i_side,
    output logic                 o_vld,
    output logic [15:0]          o_select,
    output logic                 o_dflt,
    output logic [15:0]          o_dist
);

    logic        r_vld;
    logic [15:0] r_select;
    logic        r_dflt;
    logic [15:0] r_dist;
    logic [15:0] n_select;

    always_comb begin
        if (i_side.dflt) begin
            n_select = dss_spad_pkg::SPAD_DEFAULT;
        end else if (i_side.sat) begin
            n_select = dss_spad_pkg::SAT16;
        end else begin
            n_select = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_select <= n_select;
            r_dflt   <= i_side.dflt;
            r_dist   <= i_side.dist_mm;
        end
    end

    assign o_vld    = r_vld;
    assign o_select = r_select;
    assign o_dflt   = r_dflt;
    assign o_dist   = r_dist;

endmodule

@@ rtl/dss_spad_select_and_range_scaler_top.sv @@
// Top level of the dynamic SPAD select and range scaler.
//
//  Channel   Direction  Transfer when               Carries
//  s_axis    in         tvalid & tready             one ranging result
//  m_axis    out        tvalid & tready             SPAD select, default flag, distance
//  apb       in/out     psel & penable & pwrite     target total rate register
//
// One transfer is taken per cycle and one result leaves per cycle while m_axis does not stall.
// From input transfer to result, an item passes through one entry stage,
// 32 cells of the per-SPAD rate divider (one quotient bit per cell),
// one join stage, 16 cells of the SPAD select divider and the output register.
// A stall on m_axis freezes the whole cell chain; a one-entry skid at the input
// still takes one transfer during a stall, so s_axis_tready is a register.
// Synchronous active-low reset empties the chain and the skid and loads the
// target rate with 2560.
`timescale 1ns / 1ps

`include "dss_spad_select_and_range_scaler_top_macros.svh"

module dss_spad_select_and_range_scaler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // ranging result
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] effective_spads, [31:16] peak_rate, [47:32] ambient_rate, [63:48] raw_range
    input  logic [63:0] s_axis_tdata,
    // scaled result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] spad_select, [31:16] distance
    output logic [31:0] m_axis_tdata,
    // [0] default_used
    output logic        m_axis_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned N1 = dss_spad_pkg::DIV1_STEPS;
    localparam int unsigned N2 = dss_spad_pkg::DIV2_STEPS;
    localparam int unsigned SW = $bits(dss_spad_pkg::t_side);

    // configuration register
    logic [15:0] r_target;
    logic        w_cfg_wr;

    // input skid
    logic                r_skid_vld;
    dss_spad_pkg::t_item r_skid_item;
    logic                w_in_acc;
    logic                w_adv;
    logic                w_front_vld;
    dss_spad_pkg::t_item w_front_item;

    // first divider chain: (rate << 16) / effective_spads
    logic                d1_vld  [0:N1];
    logic [15:0]         d1_rem  [0:N1];
    logic [31:0]         d1_quo  [0:N1];
    logic [15:0]         d1_div  [0:N1];
    dss_spad_pkg::t_side d1_side [0:N1];
    logic [15:0]         w_rate;

    // second divider chain: (target << 16) / per_spad
    logic                d2_vld  [0:N2];
    logic [31:0]         d2_rem  [0:N2];
    logic [15:0]         d2_quo  [0:N2];
    logic [31:0]         d2_div  [0:N2];
    dss_spad_pkg::t_side d2_side [0:N2];

    logic [15:0] w_select;
    logic [15:0] w_dist;
    logic        w_dflt;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= dss_spad_pkg::TARGET_RESET;
        end else if (w_cfg_wr && (paddr[2] == dss_spad_pkg::REG_TARGET)) begin
            r_target <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == dss_spad_pkg::REG_TARGET) ? {16'd0, r_target} : 32'd0;

    // ---------------------------------------------------------------- input skid
    // advance the whole chain unless the output register holds a result not taken
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !r_skid_vld;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_adv) begin
            r_skid_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_skid_vld <= 1'b1;
        end
    end

    // park a transfer taken during a stall
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !w_adv) begin
            r_skid_item <= dss_spad_pkg::t_item'(s_axis_tdata);
        end
    end

    assign w_front_vld  = r_skid_vld || w_in_acc;
    assign w_front_item = r_skid_vld ? r_skid_item : dss_spad_pkg::t_item'(s_axis_tdata);

    // ---------------------------------------------------------------- entry stage
    dss_spad_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (w_front_vld),
        .i_item  (w_front_item),
        .o_vld   (d1_vld[0]),
        .o_rate  (w_rate),
        .o_spads (d1_div[0]),
        .o_side  (d1_side[0])
    );

    // dividend is the rate with sixteen zero fraction bits below it
    assign d1_rem[0] = 16'd0;
    assign d1_quo[0] = {w_rate, 16'd0};

    for (genvar g = 0; g < N1; g++) begin : g_div1
        dss_spad_div_cell #(
            .RW (16),
            .DW (32),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (d1_vld[g]),
            .i_rem   (d1_rem[g]),
            .i_quo   (d1_quo[g]),
            .i_div   (d1_div[g]),
            .i_side  (d1_side[g]),
            .o_vld   (d1_vld[g+1]),
            .o_rem   (d1_rem[g+1]),
            .o_quo   (d1_quo[g+1]),
            .o_div   (d1_div[g+1]),
            .o_side  (d1_side[g+1])
        );
    end

    // ---------------------------------------------------------------- join
    dss_spad_join u_join (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_vld      (d1_vld[N1]),
        .i_per_spad (d1_quo[N1]),
        .i_side     (d1_side[N1]),
        .i_target   (r_target),
        .o_vld      (d2_vld[0]),
        .o_rem      (d2_rem[0]),
        .o_quo      (d2_quo[0]),
        .o_div      (d2_div[0]),
        .o_side     (d2_side[0])
    );

    for (genvar g = 0; g < N2; g++) begin : g_div2
        dss_spad_div_cell #(
            .RW (32),
            .DW (16),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (d2_vld[g]),
            .i_rem   (d2_rem[g]),
            .i_quo   (d2_quo[g]),
            .i_div   (d2_div[g]),
            .i_side  (d2_side[g]),
            .o_vld   (d2_vld[g+1]),
            .o_rem   (d2_rem[g+1]),
            .o_quo   (d2_quo[g+1]),
            .o_div   (d2_div[g+1]),
            .o_side  (d2_side[g+1])
        );
    end

    // ---------------------------------------------------------------- output
    dss_spad_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_vld    (d2_vld[N2]),
        .i_quo    (d2_quo[N2]),
        .i_side   (d2_side[N2]),
        .o_vld    (m_axis_tvalid),
        .o_select (w_select),
        .o_dflt   (w_dflt),
        .o_dist   (w_dist)
    );

    assign m_axis_tdata = {w_dist, w_select};
    assign m_axis_tuser = w_dflt;

    // ---------------------------------------------------------------- checks
    `DSS_SPAD_ASSERT_NXT(a_skid_fill, i_clk, i_rst_n, w_in_acc && !w_adv, r_skid_vld)
    `DSS_SPAD_ASSERT_NXT(a_skid_hold, i_clk, i_rst_n, r_skid_vld && !w_adv, r_skid_vld)
    `DSS_SPAD_ASSERT_IMP(a_dflt_value, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:0] == dss_spad_pkg::SPAD_DEFAULT)
    `DSS_SPAD_ASSERT_NXT(a_cfg_write, i_clk, i_rst_n, w_cfg_wr && (paddr[2] == dss_spad_pkg::REG_TARGET), r_target == $past(pwdata[15:0]))

endmodule

@@ verif/dss_spad_select_and_range_scaler_top_tb.sv @@
// Self-checking bench for the SPAD select and range scaler: stream traffic against a predictor.
`timescale 1ns / 1ps

module dss_spad_select_and_range_scaler_top_tb;

    localparam int CLK_PERIOD        = 12;
    localparam int RESET_CYCLES      = 5;
    localparam int RANDOM_PER_PHASE  = 117;
    localparam int NUM_PHASES        = 8;
    localparam int DRAIN_CYCLES      = 60;      // longer than the pipeline, entry stage to output register
    localparam int TIMEOUT_CYCLES    = 500_000;
    localparam int LONG_HOLD_CYCLES  = 160;
    localparam int LONG_HOLD_EVERY   = 400;

    // register map: index taken from paddr[2]
    localparam logic [2:0] TARGET_ADDR = {dss_spad_pkg::REG_TARGET, 2'b00};

    // arithmetic of the predictor, kept independent of the RTL package
    localparam logic [15:0] SELECT_DEFAULT = 16'h8000;
    localparam logic [15:0] SELECT_MAX     = 16'hFFFF;
    localparam logic [31:0] DIST_MUL       = 32'd2011;
    localparam logic [31:0] DIST_ROUND     = 32'h0000_0400;
    localparam logic [15:0] TARGET_AT_RST  = 16'd2560;

    typedef struct packed {
        logic [15:0] spad_select;
        logic        default_used;
        logic [15:0] distance;
    } t_scaled;

    // kinds of random measurement, chosen to reach every branch of the selection
    typedef enum logic [2:0] {
        MEAS_UNIFORM,
        MEAS_FEW_SPADS,
        MEAS_LOW_RATE,
        MEAS_NO_SPADS,
        MEAS_NO_RATE,
        MEAS_RATE_OVF
    } t_meas_kind;

    // receiver readiness patterns
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] effective_spads, [31:16] peak_rate, [47:32] ambient_rate, [63:48] raw_range
    dss_spad_pkg::t_item s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] spad_select, [31:16] distance
    logic [31:0] m_axis_tdata;
    // [0] default_used
    logic        m_axis_tuser;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // measurements waiting to be offered, and results still owed by the block
    dss_spad_pkg::t_item meas_q[$];
    t_scaled     scaled_q[$];

    // target rate as the block should currently hold it
    logic [15:0] target_rate = TARGET_AT_RST;

    int          err_cnt = 0;

    // sender burst state
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    bit          tx_offer;

    // receiver stall state
    t_rx_mode    rx_mode = RX_ALWAYS;
    int unsigned rx_cyc = 0;
    int unsigned rx_seen = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = LONG_HOLD_EVERY;
    bit          rx_ready;

    t_scaled     got_want;

    dss_spad_select_and_range_scaler_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Work out the SPAD select, the fallback flag and the scaled distance for one
    // measurement under the given target rate.
    function automatic t_scaled predict_scaled(input dss_spad_pkg::t_item meas,
                                               input logic [15:0] tgt);
        logic [16:0] rate_sum;
        logic [15:0] rate;
        logic [31:0] per_spad;
        logic [31:0] wanted;
        logic [31:0] dist_full;
        t_scaled     res;
        res.spad_select  = SELECT_DEFAULT;
        res.default_used = 1'b1;
        rate_sum = {1'b0, meas.peak_rate} + {1'b0, meas.ambient_rate};
        rate     = rate_sum[16] ? SELECT_MAX : rate_sum[15:0];
        if (meas.effective_spads != 16'd0) begin
            per_spad = {rate, 16'h0000} / {16'h0000, meas.effective_spads};
            if (per_spad != 32'd0) begin
                wanted           = {tgt, 16'h0000} / per_spad;
                res.spad_select  = (wanted > {16'h0000, SELECT_MAX}) ? SELECT_MAX : wanted[15:0];
                res.default_used = 1'b0;
            end
        end
        dist_full    = {16'h0000, meas.raw_range} * DIST_MUL + DIST_ROUND;
        res.distance = dist_full[26:11];
        return res;
    endfunction

    function automatic dss_spad_pkg::t_item rand_measurement();
        dss_spad_pkg::t_item m;
        t_meas_kind  kind;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)      kind = MEAS_UNIFORM;
        else if (pick == 4) kind = MEAS_FEW_SPADS;
        else if (pick <= 6) kind = MEAS_LOW_RATE;
        else if (pick == 7) kind = MEAS_NO_SPADS;
        else if (pick == 8) kind = MEAS_NO_RATE;
        else                kind = MEAS_RATE_OVF;
        m = dss_spad_pkg::t_item'({$urandom, $urandom});
        case (kind)
            MEAS_FEW_SPADS: begin
                m.effective_spads = 16'($urandom_range(1, 255));
            end
            MEAS_LOW_RATE: begin
                m.effective_spads = 16'($urandom_range(16'h4000, 16'hFFFF));
                m.peak_rate       = 16'($urandom_range(0, 3));
                m.ambient_rate    = 16'($urandom_range(0, 3));
            end
            MEAS_NO_SPADS: begin
                m.effective_spads = '0;
            end
            MEAS_NO_RATE: begin
                m.peak_rate    = '0;
                m.ambient_rate = '0;
            end
            MEAS_RATE_OVF: begin
                m.peak_rate    = 16'($urandom_range(16'h8000, 16'hFFFF));
                m.ambient_rate = 16'($urandom_range(16'h8000, 16'hFFFF));
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic queue_measurement(input logic [15:0] spads, input logic [15:0] peak,
                                     input logic [15:0] amb, input logic [15:0] range_mm);
        dss_spad_pkg::t_item m;
        m.effective_spads = spads;
        m.peak_rate       = peak;
        m.ambient_rate    = amb;
        m.raw_range       = range_mm;
        meas_q.push_back(m);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] mismatch on %s: got 0x%04h, want 0x%04h", $time, what, got, want);
        err_cnt++;
    endtask

    // Wait, sampling at the falling edge, until nothing is queued, offered or owed.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (meas_q.size() != 0 || s_axis_tvalid || scaled_q.size() != 0);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the edge
    // that closes the access cycle.
    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == TARGET_ADDR) begin
            target_rate = data[15:0];
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offer queued measurements in bursts of random length, with
    // random gaps between bursts. Predict each result at the moment of
    // transfer so that the target rate in force is the one used.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            tx_offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                scaled_q.push_back(predict_scaled(s_axis_tdata, target_rate));
                tx_offer = 1'b0;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (!tx_offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (meas_q.size() != 0) begin
                    s_axis_tdata <= meas_q.pop_front();
                    tx_offer = 1'b1;
                end
            end
            // hold valid high across back-to-back transfers: one assignment per edge
            s_axis_tvalid <= tx_offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: keep switching to a readiness pattern picked at random, and now and then
    // hold off for a long stretch so that the pipeline and the input skid
    // fill up and the block must drop s_axis_tready.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_seen++;
            end
            rx_cyc++;
            if (rx_cyc % 48 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            end
            if (hold_left == 0 && rx_seen >= next_hold_at) begin
                hold_left    = LONG_HOLD_CYCLES;
                next_hold_at = next_hold_at + LONG_HOLD_EVERY;
            end
            if (hold_left > 0) begin
                hold_left--;
                rx_ready = 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   rx_ready = 1'b1;
                    RX_COIN:     rx_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE:   rx_ready = ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: rx_ready = (rx_cyc % 4 != 3);
                    default:     rx_ready = 1'b1;
                endcase
            end
            m_axis_tready <= rx_ready;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every result transfer, field by field, with the
    // oldest prediction still owed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (scaled_q.size() == 0) begin
                report_mismatch("result with nothing owed", m_axis_tdata[15:0], 16'h0000);
            end else begin
                got_want = scaled_q.pop_front();
                if (m_axis_tdata[15:0] !== got_want.spad_select) begin
                    report_mismatch("spad_select", m_axis_tdata[15:0], got_want.spad_select);
                end
                if (m_axis_tuser !== got_want.default_used) begin
                    report_mismatch("default_used", {15'd0, m_axis_tuser},
                                    {15'd0, got_want.default_used});
                end
                if (m_axis_tdata[31:16] !== got_want.distance) begin
                    report_mismatch("distance", m_axis_tdata[31:16], got_want.distance);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, a directed set under the reset target, then random
    // phases each under a new target rate. Queue work is done at the falling
    // edge so the sender never races the fill.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] cfg_word;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero SPAD count, with everything else at both extremes
        queue_measurement(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_measurement(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // zero total rate: per-SPAD quotient is zero
        queue_measurement(16'h0100, 16'h0000, 16'h0000, 16'h0001);
        queue_measurement(16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF);
        // tiny quotient under a large target: select saturates
        queue_measurement(16'hFFFF, 16'h0001, 16'h0000, 16'd1018);
        queue_measurement(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF);
        queue_measurement(16'h8000, 16'h0001, 16'h0000, 16'h8000);
        // huge quotient: select rounds down to zero without the fallback
        queue_measurement(16'h0001, 16'hFFFF, 16'h0000, 16'h0400);
        // rate sum past 16 bits, and exactly at the top
        queue_measurement(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0002);
        queue_measurement(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_measurement(16'h0100, 16'h8000, 16'h8000, 16'h0001);
        queue_measurement(16'h0100, 16'h7FFF, 16'h8000, 16'h0003);
        // ordinary operating points
        queue_measurement(16'h0A00, 16'h0A00, 16'h0000, 16'd1000);
        queue_measurement(16'h0001, 16'h0001, 16'h0000, 16'h0001);
        queue_measurement(16'h0002, 16'h0000, 16'h0001, 16'h0001);
        // alternating bit patterns
        queue_measurement(16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
        queue_measurement(16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // target extremes first, then random words, and the reset target last (upper bits are don't-care)
            case (ph)
                0:       cfg_word = 32'h0000_0000;
                1:       cfg_word = 32'h0000_FFFF;
                2:       cfg_word = 32'h0000_0001;
                7:       cfg_word = {16'h0000, TARGET_AT_RST};
                default: cfg_word = $urandom;
            endcase
            cfg_write(TARGET_ADDR, cfg_word);
            @(negedge i_clk);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                meas_q.push_back(rand_measurement());
            end
            wait_idle();
        end

        // let the pipeline run dry so that a stray result would still be seen
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[%0t] timeout, %0d results still owed", $time, scaled_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
